// ===== hdl/ipid_pkg.sv =====
package ipid_pkg;

   localparam int DATA_W        = 32;
   localparam int CSR_W         = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int ALPHA_W       = 17;
   localparam int DT_W          = 17;
   localparam int LIMIT_W       = 31;
   localparam int ALPHA_FRAC    = 16;
   localparam int FRAC_BITS_DEF = 16;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_ALPHA  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_TAU    = 3'd5;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam logic [DATA_W-1:0]  TAU_RESET = 32'd655;

   typedef enum logic [4:0] {
      ST_NOP,
      ST_CLEAR,
      ST_PREP,
      ST_MUL_ARAW,
      ST_MUL_BLAST,
      ST_FILT,
      ST_MUL_P,
      ST_MUL_I,
      ST_TERM_I,
      ST_MUL_DT,
      ST_DI,
      ST_QUOT,
      ST_MUL_AD,
      ST_SD,
      ST_MUL_D,
      ST_CURD,
      ST_COMMIT
   } step_type;

   typedef struct packed {
      step_type step;
      logic     load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_status_type;

endpackage

// ===== hdl/incremental_pid_controller.sv =====
// channel   | handshake                  | payload
// req       | req_valid / req_ready      | req_opcode, req_setpoint, req_measurement,
//           |                            | req_step_time
// rsp       | rsp_valid / rsp_ready      | rsp_control_output, rsp_clamped
// csr       | csr_write_en (no wait)     | csr_index, csr_wdata
//
// a compute transaction steps from the prepare state through the multiply, filter, divide-wait and
// quotient states to commit; the bit-serial dividers for the derivative rate and filter weight
// set most of its length
// a clear transaction goes from idle to the clear state and back to idle
// one transaction in flight; the next one is taken while a result waits in the output register
// a result that is not taken holds the next commit or clear step until rsp_ready
// reset is synchronous, active high; control, configuration and loop state registers return to their reset values
module incremental_pid_controller #(
   parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_write_en,
   input  logic [ipid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ipid_pkg::CSR_W-1:0]         csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic signed [ipid_pkg::DATA_W-1:0] req_setpoint,
   input  logic signed [ipid_pkg::DATA_W-1:0] req_measurement,
   input  logic [ipid_pkg::DT_W-1:0]          req_step_time,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ipid_pkg::DATA_W-1:0] rsp_control_output,
   output logic                               rsp_clamped
);

   ipid_pkg::dp_cmd_type    cmd;
   ipid_pkg::dp_status_type status;

   // sequencer: walks the multiply, round and divide steps
   ipid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: config registers, loop state, shared multiplier, two dividers
   ipid_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_setpoint       (req_setpoint),
      .req_measurement    (req_measurement),
      .req_step_time      (req_step_time),
      .rsp_control_output (rsp_control_output),
      .rsp_clamped        (rsp_clamped),
      .cmd                (cmd),
      .status             (status)
   );

   // quotients are read only after both dividers finish
   a_quot_after_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == ipid_pkg::ST_QUOT) |-> !status.div_busy)
      else $error("quotient read while divider busy");

   // one transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

   // a new result only comes from a commit or a clear
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(cmd.step) == ipid_pkg::ST_COMMIT ||
                            $past(cmd.step) == ipid_pkg::ST_CLEAR))
      else $error("response raised without commit");

endmodule

// ===== hdl/ipid_div.sv =====
module ipid_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic             take;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      take    = (trial >= {1'b0, den_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[NUM_W-2:0], take};
         rem_in  = take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/ipid_ctrl.sv =====
module ipid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ipid_pkg::dp_cmd_type    cmd,
   input  ipid_pkg::dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_PREP, S_MA, S_MB, S_FILT, S_MP, S_MI, S_TI, S_MDT, S_DI,
      S_DWAIT, S_QUOT, S_MAD, S_SD, S_MD, S_CURD, S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE:   if (req_valid) begin
            state_in = req_opcode ? S_CLEAR : S_PREP;
         end
         S_CLEAR:  if (slot_free) begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_PREP:   state_in = S_MA;
         S_MA:     state_in = S_MB;
         S_MB:     state_in = S_FILT;
         S_FILT:   state_in = S_MP;
         S_MP:     state_in = S_MI;
         S_MI:     state_in = S_TI;
         S_TI:     state_in = S_MDT;
         S_MDT:    state_in = S_DI;
         S_DI:     state_in = S_DWAIT;
         S_DWAIT:  if (!status.div_busy) begin
            state_in = S_QUOT;
         end
         S_QUOT:   state_in = S_MAD;
         S_MAD:    state_in = S_SD;
         S_SD:     state_in = S_MD;
         S_MD:     state_in = S_CURD;
         S_CURD:   state_in = S_COMMIT;
         S_COMMIT: if (slot_free) begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd.load = req_valid && (state_ff == S_IDLE);
      case (state_ff)
         S_CLEAR:  cmd.step = slot_free ? ipid_pkg::ST_CLEAR : ipid_pkg::ST_NOP;
         S_PREP:   cmd.step = ipid_pkg::ST_PREP;
         S_MA:     cmd.step = ipid_pkg::ST_MUL_ARAW;
         S_MB:     cmd.step = ipid_pkg::ST_MUL_BLAST;
         S_FILT:   cmd.step = ipid_pkg::ST_FILT;
         S_MP:     cmd.step = ipid_pkg::ST_MUL_P;
         S_MI:     cmd.step = ipid_pkg::ST_MUL_I;
         S_TI:     cmd.step = ipid_pkg::ST_TERM_I;
         S_MDT:    cmd.step = ipid_pkg::ST_MUL_DT;
         S_DI:     cmd.step = ipid_pkg::ST_DI;
         S_QUOT:   cmd.step = ipid_pkg::ST_QUOT;
         S_MAD:    cmd.step = ipid_pkg::ST_MUL_AD;
         S_SD:     cmd.step = ipid_pkg::ST_SD;
         S_MD:     cmd.step = ipid_pkg::ST_MUL_D;
         S_CURD:   cmd.step = ipid_pkg::ST_CURD;
         S_COMMIT: cmd.step = slot_free ? ipid_pkg::ST_COMMIT : ipid_pkg::ST_NOP;
         default:  cmd.step = ipid_pkg::ST_NOP;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/ipid_dp.sv =====
module ipid_dp #(
   parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ipid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipid_pkg::CSR_W-1:0]           csr_wdata,
   input  logic signed [ipid_pkg::DATA_W-1:0]   req_setpoint,
   input  logic signed [ipid_pkg::DATA_W-1:0]   req_measurement,
   input  logic [ipid_pkg::DT_W-1:0]            req_step_time,
   output logic signed [ipid_pkg::DATA_W-1:0]   rsp_control_output,
   output logic                                 rsp_clamped,
   input  ipid_pkg::dp_cmd_type                 cmd,
   output ipid_pkg::dp_status_type              status
);

   localparam int DW  = ipid_pkg::DATA_W;
   localparam int EW  = 68;
   localparam int MW  = DW + 1;
   localparam int PW  = 2 * MW;
   localparam int DVW = DW + FRAC_BITS;
   localparam int DSW = DW + 1;
   localparam longint DT_DEF_I = ((longint'(1) << (FRAC_BITS + 1)) + 50) / 100;
   localparam logic [FRAC_BITS:0] DT_DEFAULT = (FRAC_BITS + 1)'(DT_DEF_I);
   localparam logic [DW-1:0] ONE_FX = DW'(longint'(1) << FRAC_BITS);
   localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

   function automatic logic signed [EW-1:0] sx(input logic signed [DW-1:0] v);
      return {{(EW-DW){v[DW-1]}}, v};
   endfunction

   function automatic logic signed [DW-1:0] sat(input logic signed [EW-1:0] v);
      if (v[EW-1:DW-1] == '0 || v[EW-1:DW-1] == '1) begin
         return v[DW-1:0];
      end else if (v[EW-1]) begin
         return MIN_V;
      end else begin
         return MAX_V;
      end
   endfunction

   // round half up
   function automatic logic signed [EW-1:0] rnd(input logic signed [EW-1:0] v, input int sh);
      logic signed [EW-1:0] half;
      half = EW'(longint'(1) << (sh - 1));
      return (v + half) >>> sh;
   endfunction

   // configuration
   logic [DW-1:0]                   gain_p_ff, gain_i_ff, gain_d_ff, tau_ff;
   logic [ipid_pkg::LIMIT_W-1:0]    limit_ff;
   logic [ipid_pkg::ALPHA_W-1:0]    alpha_ff;
   // item and intermediates
   logic signed [DW-1:0]            sp_ff, meas_ff, raw_ff, filt_ff, dp_ff, t_ff, di_ff;
   logic signed [DW-1:0]            draw_ff, curd_ff;
   logic [FRAC_BITS:0]              dt_ff, ad_ff;
   logic                            mneg_ff;
   logic signed [EW-1:0]            sum_ff;
   logic signed [PW-1:0]            prod_ff;
   // controller state
   logic signed [DW-1:0]            lfe_ff, lm_ff, sd_ff, ld_ff, acc_ff;
   logic                            first_ff;
   logic signed [DW-1:0]            out_ctl_ff;
   logic                            out_clamp_ff;

   logic [ipid_pkg::ALPHA_W-1:0]    alpha_eff, one_minus;
   logic [DW-1:0]                   st32;
   logic                            dt_bad;
   logic [FRAC_BITS:0]              dt_eff;
   logic signed [MW-1:0]            mul_a, mul_b;
   logic signed [EW-1:0]            prod_x;
   logic signed [DW-1:0]            mdiff, ediff, prev_err;
   logic [DW-1:0]                   mmag;
   logic [DVW-1:0]                  num1, num2, q1, q2;
   logic [DSW-1:0]                  den1, den2;
   logic                            busy1, busy2, div_start;
   logic signed [DW-1:0]            acc_sat, acc_fin, lim_s;
   logic                            hit;

   assign alpha_eff = (alpha_ff > ipid_pkg::ALPHA_ONE) ? ipid_pkg::ALPHA_ONE : alpha_ff;
   assign one_minus = ipid_pkg::ALPHA_ONE - alpha_eff;
   assign st32      = DW'(req_step_time);
   assign dt_bad    = (st32 == '0) || (st32 > ONE_FX);
   assign dt_eff    = dt_bad ? DT_DEFAULT : st32[FRAC_BITS:0];
   assign prod_x    = EW'(prod_ff);
   assign prev_err  = first_ff ? raw_ff : lfe_ff;
   assign ediff     = sat(sx(filt_ff) - sx(prev_err));
   assign mdiff     = first_ff ? '0 : sat(sx(meas_ff) - sx(lm_ff));
   assign mmag      = mdiff[DW-1] ? DW'(-mdiff) : DW'(mdiff);

   // dividers: derivative rate and derivative filter weight
   assign div_start = (cmd.step == ipid_pkg::ST_PREP);
   assign num1 = {mmag, {FRAC_BITS{1'b0}}};
   assign den1 = DSW'(dt_ff);
   assign num2 = DVW'({dt_ff, {FRAC_BITS{1'b0}}});
   assign den2 = DSW'(tau_ff) + DSW'(dt_ff);

   ipid_div #(.NUM_W(DVW), .DEN_W(DSW)) u_div_rate (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(num1), .denom(den1), .busy(busy1), .quot(q1)
   );

   ipid_div #(.NUM_W(DVW), .DEN_W(DSW)) u_div_weight (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(num2), .denom(den2), .busy(busy2), .quot(q2)
   );

   assign status.div_busy = busy1 || busy2;

   // shared multiplier operand select
   always_comb begin
      case (cmd.step)
         ipid_pkg::ST_MUL_ARAW: begin
            mul_a = MW'(alpha_eff);
            mul_b = MW'(raw_ff);
         end
         ipid_pkg::ST_MUL_BLAST: begin
            mul_a = MW'(one_minus);
            mul_b = MW'(lfe_ff);
         end
         ipid_pkg::ST_MUL_P: begin
            mul_a = MW'(gain_p_ff);
            mul_b = MW'(ediff);
         end
         ipid_pkg::ST_MUL_I: begin
            mul_a = MW'(gain_i_ff);
            mul_b = MW'(filt_ff);
         end
         ipid_pkg::ST_MUL_DT: begin
            mul_a = MW'(t_ff);
            mul_b = MW'(dt_ff);
         end
         ipid_pkg::ST_MUL_AD: begin
            mul_a = MW'(ad_ff);
            mul_b = MW'(sat(sx(draw_ff) - sx(sd_ff)));
         end
         ipid_pkg::ST_MUL_D: begin
            mul_a = MW'(gain_d_ff);
            mul_b = MW'(sd_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // accumulate and clamp
   always_comb begin
      acc_sat = sat(sx(acc_ff) + sx(dp_ff) + sx(di_ff) + sx(sat(sx(curd_ff) - sx(ld_ff))));
      lim_s   = DW'(limit_ff);
      acc_fin = acc_sat;
      hit     = 1'b0;
      if (acc_sat > lim_s) begin
         acc_fin = lim_s;
         hit     = 1'b1;
      end else if (acc_sat < -lim_s) begin
         acc_fin = -lim_s;
         hit     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         limit_ff  <= '0;
         alpha_ff  <= ipid_pkg::ALPHA_ONE;
         tau_ff    <= ipid_pkg::TAU_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ipid_pkg::REG_GAIN_P:       gain_p_ff <= csr_wdata;
            ipid_pkg::REG_GAIN_I:       gain_i_ff <= csr_wdata;
            ipid_pkg::REG_GAIN_D:       gain_d_ff <= csr_wdata;
            ipid_pkg::REG_OUTPUT_LIMIT: limit_ff  <= csr_wdata[ipid_pkg::LIMIT_W-1:0];
            ipid_pkg::REG_ERROR_ALPHA:  alpha_ff  <= csr_wdata[ipid_pkg::ALPHA_W-1:0];
            ipid_pkg::REG_DERIV_TAU:    tau_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sp_ff   <= req_setpoint;
         meas_ff <= req_measurement;
         dt_ff   <= dt_eff;
      end
      prod_ff <= PW'(mul_a) * PW'(mul_b);
      case (cmd.step)
         ipid_pkg::ST_PREP: begin
            raw_ff  <= sat(sx(sp_ff) - sx(meas_ff));
            mneg_ff <= mdiff[DW-1];
         end
         ipid_pkg::ST_MUL_BLAST: sum_ff  <= prod_x;
         ipid_pkg::ST_FILT:
            filt_ff <= first_ff ? raw_ff : sat(rnd(sum_ff + prod_x, ipid_pkg::ALPHA_FRAC));
         ipid_pkg::ST_MUL_I:  dp_ff   <= sat(rnd(prod_x, FRAC_BITS));
         ipid_pkg::ST_TERM_I: t_ff    <= sat(rnd(prod_x, FRAC_BITS));
         ipid_pkg::ST_DI:     di_ff   <= sat(rnd(prod_x, FRAC_BITS));
         ipid_pkg::ST_QUOT: begin
            draw_ff <= sat(mneg_ff ? -$signed(EW'(q1)) : $signed(EW'(q1)));
            ad_ff   <= q2[FRAC_BITS:0];
         end
         ipid_pkg::ST_CURD:   curd_ff <= sat(-rnd(prod_x, FRAC_BITS));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.step == ipid_pkg::ST_CLEAR) begin
         lfe_ff       <= '0;
         lm_ff        <= '0;
         sd_ff        <= '0;
         ld_ff        <= '0;
         acc_ff       <= '0;
         first_ff     <= 1'b1;
         out_ctl_ff   <= '0;
         out_clamp_ff <= 1'b0;
      end else begin
         case (cmd.step)
            ipid_pkg::ST_SD: sd_ff <= sat(sx(sd_ff) + rnd(prod_x, FRAC_BITS));
            ipid_pkg::ST_COMMIT: begin
               acc_ff       <= acc_fin;
               lfe_ff       <= filt_ff;
               lm_ff        <= meas_ff;
               ld_ff        <= curd_ff;
               first_ff     <= 1'b0;
               out_ctl_ff   <= acc_fin;
               out_clamp_ff <= hit;
            end
            default: ;
         endcase
      end
   end

   assign rsp_control_output = out_ctl_ff;
   assign rsp_clamped        = out_clamp_ff;

endmodule
